### sv/wsieve_pkg.sv
// Shared constants, types and helpers for the wheel-6 prime sieve.
package wsieve_pkg;

   // Store geometry
   localparam int MAX_BYTES = 1024;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int BYTE_W    = 8;
   localparam int BIT_SEL_W = $clog2(BYTE_W);

   // Field and datapath widths
   localparam int IDX_W     = 13;
   localparam int BYTES_W   = 11;
   localparam int CAND_W    = 6;   // sieving root index, walk ends by i = 37
   localparam int ROOT_W    = 8;   // 6i+1 / 6i+5 for the roots that get walked
   localparam int MULT_W    = 17;  // current multiple
   localparam int QUOT_W    = 14;  // multiple / 6
   localparam int BOUND_W   = 16;  // 6*(8*bytes-1)+5 = 48*bytes-1
   localparam int RES_W     = 3;   // multiple mod 6 (1, 3 or 5)

   // Stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   // Opcodes
   localparam logic OP_BUILD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Residues met while stepping odd multiples
   localparam logic [RES_W-1:0] RES_ONE   = 3'd1;
   localparam logic [RES_W-1:0] RES_THREE = 3'd3;
   localparam logic [RES_W-1:0] RES_FIVE  = 3'd5;
   localparam logic [RES_W:0]   RES_WRAP  = 4'd6;
   localparam logic [RES_W:0]   STEP_R_ONE  = 4'd2;  // 2p mod 6 for p = 6i+1
   localparam logic [RES_W:0]   STEP_R_FIVE = 4'd4;  // 2p mod 6 for p = 6i+5

   // Value written to byte 0 of the 6i+1 store on clear (marks the number 1)
   localparam logic [BYTE_W-1:0] ONE_MARK = 8'h01;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUERY_READ,
      ST_CLEAR,
      ST_CAND_START,
      ST_CAND_CHECK,
      ST_WALK_INIT,
      ST_WALK_TEST,
      ST_WALK_WRITE,
      ST_RESULT
   } state_type;

   // Controller to multiple walker
   typedef struct packed {
      logic init;      // load first multiple p^2 of the root
      logic sel_five;  // root is 6i+5 (else 6i+1)
      logic advance;   // step to the next odd multiple
   } walk_ctrl_type;

   // Multiple walker to controller
   typedef struct packed {
      logic              beyond;   // multiple exceeds the bound
      logic [RES_W-1:0]  residue;  // multiple mod 6
      logic [QUOT_W-1:0] quot;     // multiple / 6, the store index
   } walk_stat_type;

   // Effective byte count: zero reads as one, large values clip to the store size
   function automatic logic [BYTES_W-1:0] used_bytes(input logic [BYTES_W-1:0] raw);
      logic [BYTES_W-1:0] res;
      res = raw;
      if (raw == '0) begin
         res = BYTES_W'(1);
      end else if (raw > BYTES_W'(MAX_BYTES)) begin
         res = BYTES_W'(MAX_BYTES);
      end
      return res;
   endfunction

endpackage

### sv/wsieve_ram.sv
// Generic single-port synchronous RAM with registered read data.
module wsieve_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/wsieve_walk.sv
// Multiple walker: steps p^2, p^2+2p, ... keeping value, value/6 and value mod 6.
module wsieve_walk
   import wsieve_pkg::*;
(
   input  logic                clock,
   input  logic [CAND_W-1:0]   cand,
   input  logic [BOUND_W-1:0]  bound,
   input  walk_ctrl_type       ctrl,
   output walk_stat_type       stat
);

   logic [MULT_W-1:0]   v_ff;
   logic [QUOT_W-1:0]   q_ff;
   logic [RES_W-1:0]    r_ff;
   logic [ROOT_W:0]     stepv_ff;
   logic [CAND_W:0]     stepq_ff;
   logic [RES_W:0]      stepr_ff;

   logic [ROOT_W-1:0]   cand_x;
   logic [ROOT_W-1:0]   root;
   logic [ROOT_W-1:0]   fb;
   logic [CAND_W-1:0]   fa;
   logic [2*ROOT_W-1:0] root_sq;
   logic [QUOT_W-1:0]   quot0;
   logic [RES_W:0]      r_sum;
   logic                wrap;

   // root p = 6i+1 or 6i+5; p^2/6 = i(6i+2) or (i+1)(6i+4)
   always_comb begin
      cand_x  = ROOT_W'(cand);
      root    = cand_x * ROOT_W'(6) + (ctrl.sel_five ? ROOT_W'(5) : ROOT_W'(1));
      fa      = ctrl.sel_five ? cand + CAND_W'(1) : cand;
      fb      = cand_x * ROOT_W'(6) + (ctrl.sel_five ? ROOT_W'(4) : ROOT_W'(2));
      root_sq = {{ROOT_W{1'b0}}, root} * {{ROOT_W{1'b0}}, root};
      quot0   = QUOT_W'(fa) * QUOT_W'(fb);
   end

   // residue step with carry into the quotient
   always_comb begin
      r_sum = {1'b0, r_ff} + stepr_ff;
      wrap  = (r_sum >= RES_WRAP);
   end

   always_ff @(posedge clock) begin
      if (ctrl.init) begin
         v_ff     <= MULT_W'(root_sq);
         q_ff     <= quot0;
         r_ff     <= RES_ONE;
         stepv_ff <= {root, 1'b0};
         stepq_ff <= {cand, ctrl.sel_five};
         stepr_ff <= ctrl.sel_five ? STEP_R_FIVE : STEP_R_ONE;
      end else if (ctrl.advance) begin
         v_ff <= v_ff + MULT_W'(stepv_ff);
         q_ff <= q_ff + QUOT_W'(stepq_ff) + QUOT_W'(wrap);
         r_ff <= wrap ? RES_W'(r_sum - RES_WRAP) : RES_W'(r_sum);
      end
   end

   assign stat.beyond  = (v_ff > MULT_W'(bound));
   assign stat.residue = r_ff;
   assign stat.quot    = q_ff;

endmodule

### sv/wheel6_prime_sieve.sv
// Top level of the wheel-6 prime sieve: sequencer, stores and output register.
//
//  channel | dir | handshake            | word
//  req     | in  | req_tvalid/tready    | tuser opcode, tdata index
//  rsp     | out | rsp_tvalid/tready    | tuser build_done/out_of_range, tdata bits
//  csr     | in  | csr_wen              | bytes_in_use
//
// Query: store read at the accept edge, result formed, output loaded; no new word is
// taken before that. Build: both stores cleared, then CAND_START, CAND_CHECK per
// root candidate, WALK_TEST, WALK_WRITE per marked multiple, WALK_TEST alone per
// residue-3 multiple or walk end, WALK_INIT per 6i+5 walk; stores are single-port.
// Reset is synchronous; queries before the first build read as zero.
// A stalled rsp holds the result; the sequencer waits with the next result.
module wheel6_prime_sieve
   import wsieve_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [12:0] index, rest zero
   input  logic                  req_tuser,   // [0] opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] composite_one, [1] composite_five
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] build_done, [1] out_of_range
   input  logic                  csr_wen,
   input  logic [BYTES_W-1:0]    csr_wdata
);

   state_type state_ff, state_in;

   logic [BYTES_W-1:0] bytes_ff;
   logic [BYTES_W-1:0] used;
   logic               built_ff;
   logic [ADDR_W-1:0]  clr_ff;
   logic [CAND_W-1:0]  cand_ff;
   logic [BOUND_W-1:0] bound_ff;
   logic               sel_ff;
   logic               five_bit_ff;
   logic [BIT_SEL_W-1:0] qbit_ff;
   logic               oor_ff;

   logic pend_one_ff, pend_five_ff, pend_done_ff, pend_oor_ff;
   logic rsp_valid_ff, rsp_one_ff, rsp_five_ff, rsp_done_ff, rsp_oor_ff;

   logic [ADDR_W-1:0] ram_addr;
   logic              we_one, we_five;
   logic [BYTE_W-1:0] wd_one, wd_five, rd_one, rd_five;
   logic [BYTE_W-1:0] bit_mask;
   logic [ADDR_W-1:0] quot_byte;
   logic              slot_free;
   logic              one_bit, five_bit;
   logic              req_opcode;
   logic [IDX_W-1:0]  req_index;

   walk_ctrl_type walk_ctrl;
   walk_stat_type walk_stat;

   assign req_opcode = req_tuser;
   assign req_index  = req_tdata[IDX_W-1:0];
   assign used       = used_bytes(bytes_ff);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign quot_byte  = walk_stat.quot[ADDR_W+BIT_SEL_W-1:BIT_SEL_W];
   assign bit_mask   = BYTE_W'(1) << walk_stat.quot[BIT_SEL_W-1:0];
   assign one_bit    = rd_one[cand_ff[BIT_SEL_W-1:0]];
   assign five_bit   = rd_five[cand_ff[BIT_SEL_W-1:0]];

   // stores, one per residue class
   wsieve_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_BYTES)) u_one_ram (
      .clock (clock),
      .we    (we_one),
      .addr  (ram_addr),
      .wdata (wd_one),
      .rdata (rd_one)
   );

   wsieve_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_BYTES)) u_five_ram (
      .clock (clock),
      .we    (we_five),
      .addr  (ram_addr),
      .wdata (wd_five),
      .rdata (rd_five)
   );

   wsieve_walk u_walk (
      .clock (clock),
      .cand  (cand_ff),
      .bound (bound_ff),
      .ctrl  (walk_ctrl),
      .stat  (walk_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_opcode == OP_BUILD) ? ST_CLEAR : ST_QUERY_READ;
            end
         end
         ST_QUERY_READ: state_in = ST_RESULT;
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(MAX_BYTES - 1)) begin
               state_in = ST_CAND_START;
            end
         end
         ST_CAND_START: state_in = ST_CAND_CHECK;
         ST_CAND_CHECK: begin
            if (walk_stat.beyond) begin
               state_in = ST_RESULT;
            end else if (!one_bit) begin
               state_in = ST_WALK_TEST;
            end else if (!five_bit) begin
               state_in = ST_WALK_INIT;
            end else begin
               state_in = ST_CAND_START;
            end
         end
         ST_WALK_INIT: state_in = ST_WALK_TEST;
         ST_WALK_TEST: begin
            if (walk_stat.beyond) begin
               state_in = (!sel_ff && !five_bit_ff) ? ST_WALK_INIT : ST_CAND_START;
            end else if (walk_stat.residue != RES_THREE) begin
               state_in = ST_WALK_WRITE;
            end
         end
         ST_WALK_WRITE: state_in = ST_WALK_TEST;
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // store port, walker and handshake controls
   always_comb begin
      req_tready = 1'b0;
      ram_addr   = '0;
      we_one     = 1'b0;
      we_five    = 1'b0;
      wd_one     = '0;
      wd_five    = '0;
      walk_ctrl  = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ram_addr   = req_index[ADDR_W+BIT_SEL_W-1:BIT_SEL_W];
         end
         ST_CLEAR: begin
            ram_addr = clr_ff;
            we_one   = 1'b1;
            we_five  = 1'b1;
            wd_one   = (clr_ff == '0) ? ONE_MARK : '0;
         end
         ST_CAND_START: begin
            ram_addr       = ADDR_W'(cand_ff >> BIT_SEL_W);
            walk_ctrl.init = 1'b1;
         end
         ST_WALK_INIT: begin
            walk_ctrl.init     = 1'b1;
            walk_ctrl.sel_five = 1'b1;
         end
         ST_WALK_TEST: begin
            if (!walk_stat.beyond) begin
               if (walk_stat.residue == RES_THREE) begin
                  walk_ctrl.advance = 1'b1;
               end else begin
                  ram_addr = quot_byte;
               end
            end
         end
         ST_WALK_WRITE: begin
            ram_addr          = quot_byte;
            walk_ctrl.advance = 1'b1;
            if (walk_stat.residue == RES_ONE) begin
               we_one = 1'b1;
               wd_one = rd_one | bit_mask;
            end else begin
               we_five = 1'b1;
               wd_five = rd_five | bit_mask;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bytes_ff     <= BYTES_W'(MAX_BYTES);
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            bytes_ff <= csr_wdata;
         end
         if (state_ff == ST_CAND_CHECK && walk_stat.beyond) begin
            built_ff <= 1'b1;
         end
         if (state_ff == ST_RESULT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // build walk position and query context
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         clr_ff   <= '0;
         cand_ff  <= '0;
         bound_ff <= BOUND_W'({used, 5'b0}) + BOUND_W'({used, 4'b0}) - BOUND_W'(1);
         qbit_ff  <= req_index[BIT_SEL_W-1:0];
         oor_ff   <= ({1'b0, req_index} >= {used, 3'b0});
      end
      if (state_ff == ST_CLEAR) begin
         clr_ff <= clr_ff + ADDR_W'(1);
      end
      if (state_ff != ST_CLEAR && state_in == ST_CAND_START) begin
         cand_ff <= cand_ff + CAND_W'(1);
      end
      if (state_ff == ST_CAND_CHECK) begin
         sel_ff      <= 1'b0;
         five_bit_ff <= five_bit;
      end
      if (state_ff == ST_WALK_INIT) begin
         sel_ff <= 1'b1;
      end
   end

   // pending result
   always_ff @(posedge clock) begin
      if (state_ff == ST_QUERY_READ) begin
         pend_one_ff  <= built_ff && !oor_ff && rd_one[qbit_ff];
         pend_five_ff <= built_ff && !oor_ff && rd_five[qbit_ff];
         pend_done_ff <= 1'b0;
         pend_oor_ff  <= oor_ff;
      end else if (state_ff == ST_CAND_CHECK && walk_stat.beyond) begin
         pend_one_ff  <= 1'b0;
         pend_five_ff <= 1'b0;
         pend_done_ff <= 1'b1;
         pend_oor_ff  <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (state_ff == ST_RESULT && slot_free) begin
         rsp_one_ff  <= pend_one_ff;
         rsp_five_ff <= pend_five_ff;
         rsp_done_ff <= pend_done_ff;
         rsp_oor_ff  <= pend_oor_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2){1'b0}}, rsp_five_ff, rsp_one_ff};
   assign rsp_tuser  = {rsp_oor_ff, rsp_done_ff};

endmodule

### sv/wsieve_checker.sv
// Port-level checks on the sieve, bound to the top level.
module wsieve_checker
   import wsieve_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // build completion carries no bits and no range flag
   a_build_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("build result carries data");

   // out-of-range query reads as zero
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0)
      else $error("out-of-range query returned bits");

   // one word at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

endmodule

bind wheel6_prime_sieve wsieve_checker u_wsieve_checker (.*);
